// ===== rtl/core/gradient_noise_3d_core_assert.svh =====
// Assertion helpers shared by the core.
`ifndef GRADIENT_NOISE_3D_CORE_ASSERT_SVH
`define GRADIENT_NOISE_3D_CORE_ASSERT_SVH

// implication checked on every edge outside reset
`define GN3_AST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gn3 check failed");

// signal must be low in the cycle after reset is applied
`define GN3_AST_RST(lbl, sig) \
  lbl: assert property (@(posedge clk) !rst_n |=> !(sig)) \
    else $error("gn3 reset check failed");

`endif

// ===== rtl/core/gn3_pkg.sv =====
package gn3_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int TAW        = 8;
  localparam int COORD_W    = 24;
  localparam int OUT_W      = 18;
  localparam int OUT_MAX    = 131071;
  localparam int OUT_MIN    = -131072;
  localparam int QDEPTH     = 4;
  localparam int QAW        = 2;
  localparam int NCOPY      = 7;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               is_eval;
    logic [TAW-1:0]     perm_index;
    logic [7:0]         perm_value;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

  typedef struct packed {
    logic pop_eval;
    logic pop_load;
    logic busy;
  } back_stat_t;

  typedef enum logic [1:0] {
    VSRC_X,
    VSRC_Y,
    VSRC_Z
  } vsrc_t;

  typedef struct packed {
    logic  u_from_y;
    vsrc_t v_src;
    logic  neg_u;
    logic  neg_v;
  } gsel_t;

  function automatic gsel_t grad_sel(input logic [3:0] h);
    gsel_t s;
    s.u_from_y = h[3];
    case (h) inside
      [4'd0:4'd3]:  s.v_src = VSRC_Y;
      4'd12, 4'd14: s.v_src = VSRC_X;
      default:      s.v_src = VSRC_Z;
    endcase
    s.neg_u = h[0];
    s.neg_v = h[1];
    return s;
  endfunction

endpackage

// ===== rtl/core/gn3_if.sv =====
interface gn3_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  perm_index;
  logic [7:0]  perm_value;
  logic [23:0] coord_x;
  logic [23:0] coord_y;
  logic [23:0] coord_z;

  modport source (output valid, cmd, perm_index, perm_value, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, cmd, perm_index, perm_value, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface gn3_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

// ===== rtl/core/gn3_front.sv =====
module gn3_front (
  input  logic                clk,
  input  logic                rst_n,
  gn3_in_if.sink              in_ch,
  input  gn3_pkg::back_stat_t stat,
  output gn3_pkg::q_head_t    head
);
  import gn3_pkg::*;

  req_t           q_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           push, pop;
  req_t           req_in;

  assign in_ch.ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = stat.pop_eval || stat.pop_load;

  always_comb begin
    req_in.is_eval    = (cmd_t'(in_ch.cmd) == CMD_EVAL);
    req_in.perm_index = in_ch.perm_index;
    req_in.perm_value = in_ch.perm_value;
    req_in.coord_x    = in_ch.coord_x;
    req_in.coord_y    = in_ch.coord_y;
    req_in.coord_z    = in_ch.coord_z;
  end

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= req_in;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.req   = q_r[rp_r];

endmodule

// ===== rtl/core/gn3_back.sv =====
module gn3_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gn3_pkg::q_head_t    head,
  output gn3_pkg::back_stat_t stat,
  gn3_out_if.source           out_ch
);
  import gn3_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int GW  = F + 4;
  localparam int DW  = GW + 1;
  localparam int PW  = F + 2 + DW;
  localparam int RW  = GW + 16;
  localparam int SHR = (F > 16) ? F - 16 : 0;
  localparam int SHL = (F > 16) ? 0 : 16 - F;
  localparam logic signed [RW-1:0] SMAX = RW'(OUT_MAX);
  localparam logic signed [RW-1:0] SMIN = RW'(OUT_MIN);

  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
      input logic signed [F:0] x, input logic signed [F:0] y, input logic signed [F:0] z);
    gsel_t s;
    logic signed [GW-1:0] uu, vv;
    s  = grad_sel(h);
    uu = s.u_from_y ? GW'(y) : GW'(x);
    unique case (s.v_src)
      VSRC_X:  vv = GW'(x);
      VSRC_Y:  vv = GW'(y);
      default: vv = GW'(z);
    endcase
    return (s.neg_u ? -uu : uu) + (s.neg_v ? -vv : vv);
  endfunction

  function automatic logic signed [PW-1:0] lmul(input logic [F:0] w,
      input logic signed [DW-1:0] d);
    logic signed [F+1:0] ws;
    ws = $signed({1'b0, w});
    return PW'(ws * d);
  endfunction

  logic       adv, issue, pop_load, busy;
  logic [8:0] v_r;

  // table copies, one per lookup level / pair
  logic [TAW-1:0] ra0 [NCOPY];
  logic [TAW-1:0] ra1 [NCOPY];
  logic [7:0]     rd0 [NCOPY];
  logic [7:0]     rd1 [NCOPY];

  logic [F-1:0]   fr0 [3];
  logic [TAW-1:0] cx0, cy0, cz0;

  logic [F-1:0]     fr1_r [3];
  logic [2*F-1:0]   tt1_r [3];
  logic [TAW-1:0]   cy1_r, cz1_r;

  logic [F-1:0]     fr2_r [3];
  logic [2*F-1:0]   p2_r  [3];
  logic [F+3:0]     q2_r  [3];
  logic [TAW-1:0]   cz2_r;

  logic [F-1:0]     fr3_r [3];
  logic [2*F+3:0]   p3_r  [3];

  logic [F:0]              fd4_r [3];
  logic signed [GW-1:0]    g4_r  [8];
  logic signed [F:0]       off_f [3];
  logic signed [F:0]       off_g [3];
  logic [3:0]              hc    [8];

  logic signed [PW-1:0]    p5_r [4];
  logic signed [GW-1:0]    a5_r [4];
  logic [F:0]              v5_r, w5_r;

  logic signed [GW-1:0]    xl   [4];
  logic signed [GW-1:0]    a6_r [2];
  logic signed [DW-1:0]    d6_r [2];
  logic [F:0]              v6_r, w6_r;

  logic signed [PW-1:0]    p7_r [2];
  logic signed [GW-1:0]    a7_r [2];
  logic [F:0]              w7_r;

  logic signed [GW-1:0]    yl   [2];
  logic signed [GW-1:0]    a8_r;
  logic signed [DW-1:0]    d8_r;
  logic [F:0]              w8_r;

  logic signed [PW-1:0]    p9_r;
  logic signed [GW-1:0]    a9_r;

  logic signed [GW-1:0]    r_fin;
  logic signed [RW-1:0]    r_ext, r_scl;
  logic signed [OUT_W-1:0] r_sat;

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_val_r;

  assign busy     = |v_r;
  assign adv      = !out_valid_r || out_ch.ready;
  assign issue    = head.valid && head.req.is_eval && adv;
  assign pop_load = head.valid && !head.req.is_eval && !busy;

  assign stat.pop_eval = issue;
  assign stat.pop_load = pop_load;
  assign stat.busy     = busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[7:0], issue};
    end
  end

  always_comb begin
    cx0    = TAW'((32)'(head.req.coord_x) >> F);
    cy0    = TAW'((32)'(head.req.coord_y) >> F);
    cz0    = TAW'((32)'(head.req.coord_z) >> F);
    fr0[0] = head.req.coord_x[F-1:0];
    fr0[1] = head.req.coord_y[F-1:0];
    fr0[2] = head.req.coord_z[F-1:0];
  end

  // lookup addresses: cx, then a/b, then aa/ab/ba/bb, each with its +1 neighbor
  always_comb begin
    ra0[0] = cx0;
    ra0[1] = rd0[0] + cy1_r;
    ra0[2] = rd1[0] + cy1_r;
    ra0[3] = rd0[1] + cz2_r;
    ra0[4] = rd1[1] + cz2_r;
    ra0[5] = rd0[2] + cz2_r;
    ra0[6] = rd1[2] + cz2_r;
    for (int c = 0; c < NCOPY; c++) begin
      ra1[c] = ra0[c] + 1'b1;
    end
  end

  for (genvar c = 0; c < NCOPY; c++) begin : g_copy
    logic [7:0] mem [TABLE_SIZE];
    always_ff @(posedge clk) begin
      if (pop_load) begin
        mem[head.req.perm_index] <= head.req.perm_value;
      end
      if (adv) begin
        rd0[c] <= mem[ra0[c]];
        rd1[c] <= mem[ra1[c]];
      end
    end
  end

  // fade: t*t, then t2*t and q, then t3*q
  always_ff @(posedge clk) begin
    if (adv) begin
      cy1_r <= cy0;
      cz1_r <= cz0;
      cz2_r <= cz1_r;
      for (int i = 0; i < 3; i++) begin
        fr1_r[i] <= fr0[i];
        tt1_r[i] <= (2*F)'(fr0[i] * fr0[i]);
        fr2_r[i] <= fr1_r[i];
        p2_r[i]  <= (2*F)'(tt1_r[i][2*F-1:F] * fr1_r[i]);
        q2_r[i]  <= (F+4)'((F+5)'(10) * (F+5)'(1 << F)
                    + (F+5)'(6) * (F+5)'(tt1_r[i][2*F-1:F])
                    - (F+5)'(15) * (F+5)'(fr1_r[i]));
        fr3_r[i] <= fr2_r[i];
        p3_r[i]  <= (2*F+4)'(p2_r[i][2*F-1:F] * q2_r[i]);
        fd4_r[i] <= p3_r[i][2*F:F];
      end
    end
  end

  // corner k: bit0 x, bit1 y, bit2 z (0 = fraction, 1 = fraction - 1)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off_f[i] = $signed({1'b0, fr3_r[i]});
      off_g[i] = $signed({1'b1, fr3_r[i]});
    end
    for (int k = 0; k < 8; k++) begin
      hc[k] = k[2] ? rd1[3 + k[1] + 2*k[0]][3:0] : rd0[3 + k[1] + 2*k[0]][3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 8; k++) begin
        g4_r[k] <= grad(hc[k], k[0] ? off_g[0] : off_f[0], k[1] ? off_g[1] : off_f[1],
                        k[2] ? off_g[2] : off_f[2]);
      end
      for (int j = 0; j < 4; j++) begin
        p5_r[j] <= lmul(fd4_r[0], DW'(g4_r[2*j+1]) - DW'(g4_r[2*j]));
        a5_r[j] <= g4_r[2*j];
      end
      v5_r <= fd4_r[1];
      w5_r <= fd4_r[2];
      for (int i = 0; i < 2; i++) begin
        a6_r[i] <= xl[2*i];
        d6_r[i] <= DW'(xl[2*i+1]) - DW'(xl[2*i]);
      end
      v6_r <= v5_r;
      w6_r <= w5_r;
      for (int i = 0; i < 2; i++) begin
        p7_r[i] <= lmul(v6_r, d6_r[i]);
        a7_r[i] <= a6_r[i];
      end
      w7_r <= w6_r;
      a8_r <= yl[0];
      d8_r <= DW'(yl[1]) - DW'(yl[0]);
      w8_r <= w7_r;
      p9_r <= lmul(w8_r, d8_r);
      a9_r <= a8_r;
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      xl[j] = a5_r[j] + GW'(p5_r[j] >>> F);
    end
    for (int i = 0; i < 2; i++) begin
      yl[i] = a7_r[i] + GW'(p7_r[i] >>> F);
    end
    r_fin = a9_r + GW'(p9_r >>> F);
    r_ext = RW'(r_fin);
    r_scl = (r_ext <<< SHL) >>> SHR;
    if (r_scl > SMAX) begin
      r_sat = OUT_W'(SMAX);
    end else if (r_scl < SMIN) begin
      r_sat = OUT_W'(SMIN);
    end else begin
      r_sat = OUT_W'(r_scl);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[8];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_r[8]) begin
      out_val_r <= r_sat;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.noise_value = out_val_r;

endmodule

// ===== rtl/core/gradient_noise_3d_core.sv =====
// Path: a request waits in the queue, then passes the pipeline registers and the output register.
// Throughput: one evaluate request per cycle while the output is not stalled; a load waits
// until the evaluate pipeline has drained, which an output stall delays, then writes all
// seven table copies at once.
// Reset: synchronous, active low; clears queue, pipeline valids and output valid.
// Table contents are not reset and must be loaded before use.
module gradient_noise_3d_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  gn3_in_if.sink    in_ch,
  gn3_out_if.source out_ch
);
  import gn3_pkg::*;

  q_head_t    head;
  back_stat_t stat;

  gn3_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .stat  (stat),
    .head  (head)
  );

  gn3_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .stat   (stat),
    .out_ch (out_ch)
  );

`include "gradient_noise_3d_core_assert.svh"

  `GN3_AST(a_load_drained, stat.pop_load, !stat.busy)
  `GN3_AST(a_pop_has_head, stat.pop_eval || stat.pop_load, head.valid)
  `GN3_AST(a_full_has_head, !in_ch.ready, head.valid)
  `GN3_AST_RST(a_rst_out_idle, out_ch.valid)

endmodule

// ===== tb/gradient_noise_3d_core_test.sv =====
`timescale 1ns / 1ps

module gradient_noise_3d_core_test;
  import gn3_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1680;
  localparam int QUIET_ITEMS = 300;

  typedef struct {
    cmd_t              cmd;
    logic [7:0]        perm_index;
    logic [7:0]        perm_value;
    logic [23:0]       coord_x;
    logic [23:0]       coord_y;
    logic [23:0]       coord_z;
    bit                fixed_exp;
    logic signed [17:0] noise_exp;
  } stim_row_t;

  logic clk;
  logic rst_n;
  gn3_in_if  in_ch ();
  gn3_out_if out_ch ();

  gradient_noise_3d_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [7:0]         perm_model [TABLE_SIZE];
  logic signed [17:0] noise_expected_q [$];
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;
  bit                 quiet = 0;
  int unsigned        send_gap = 0;

  // fraction-zero rows give exactly zero whatever the table holds
  stim_row_t dir_rows [0:15] = '{
    '{CMD_EVAL, 8'h00, 8'h00, 24'h000000, 24'h000000, 24'h000000, 1, 18'sd0},
    '{CMD_EVAL, 8'hFF, 8'hFF, 24'hFF0000, 24'hFF0000, 24'hFF0000, 1, 18'sd0},
    '{CMD_EVAL, 8'hA5, 8'h5A, 24'h7F0000, 24'h800000, 24'h010000, 1, 18'sd0},
    '{CMD_EVAL, 8'h00, 8'h00, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 0, 18'sd0},
    '{CMD_EVAL, 8'h00, 8'h00, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 18'sd0},
    '{CMD_EVAL, 8'h00, 8'h00, 24'h008000, 24'h008000, 24'h008000, 0, 18'sd0},
    '{CMD_EVAL, 8'h00, 8'h00, 24'hFF8000, 24'h004000, 24'hFFC000, 0, 18'sd0},
    '{CMD_EVAL, 8'h00, 8'h00, 24'h000001, 24'hFFFFFF, 24'h000001, 0, 18'sd0},
    '{CMD_LOAD, 8'h00, 8'h00, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 18'sd0},
    '{CMD_LOAD, 8'hFF, 8'hFF, 24'hABCDEF, 24'h123456, 24'h654321, 0, 18'sd0},
    '{CMD_EVAL, 8'h00, 8'h00, 24'hFF3333, 24'hFF6666, 24'hFF9999, 0, 18'sd0},
    '{CMD_EVAL, 8'h00, 8'h00, 24'h00C000, 24'hFE2000, 24'h7FE000, 0, 18'sd0},
    '{CMD_LOAD, 8'h01, 8'hFE, 24'h000000, 24'h000000, 24'h000000, 0, 18'sd0},
    '{CMD_EVAL, 8'h00, 8'h00, 24'h00FFFF, 24'hFF0001, 24'h800000, 0, 18'sd0},
    '{CMD_EVAL, 8'h00, 8'h00, 24'h12F00F, 24'h34AAAA, 24'h565555, 0, 18'sd0},
    '{CMD_EVAL, 8'h00, 8'h00, 24'hFFFFFF, 24'h000000, 24'hFF8000, 0, 18'sd0}
  };

  function automatic longint fade_q16(input longint t);
    longint t2, t3, q;
    t2 = (t * t) >> 16;
    t3 = (t2 * t) >> 16;
    q = 10 * 65536 + 6 * t2 - 15 * t;
    return (t3 * q) >> 16;
  endfunction

  function automatic longint blend(input longint w, input longint a, input longint b);
    return a + ((w * (b - a)) >>> 16);
  endfunction

  function automatic longint corner_dot(input int hash, input longint x, input longint y,
                                        input longint z);
    int h;
    longint gu, gv;
    h = hash & 15;
    gu = (h < 8) ? x : y;
    gv = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return ((h & 1) ? -gu : gu) + ((h & 2) ? -gv : gv);
  endfunction

  function automatic int perm_at(input int i);
    return int'(perm_model[i & 255]);
  endfunction

  function automatic logic signed [17:0] noise_predict(input logic [23:0] px,
                                                        input logic [23:0] py,
                                                        input logic [23:0] pz);
    int cx, cy, cz, a, b, aa, ab, ba, bb;
    longint fx, fy, fz, gx, gy, gz, u, v, w, x1, x2, y1, y2, r;
    cx = px[23:16]; cy = py[23:16]; cz = pz[23:16];
    fx = px[15:0];  fy = py[15:0];  fz = pz[15:0];
    gx = fx - 65536; gy = fy - 65536; gz = fz - 65536;
    u = fade_q16(fx); v = fade_q16(fy); w = fade_q16(fz);
    a = perm_at(cx) + cy;
    aa = perm_at(a) + cz;
    ab = perm_at(a + 1) + cz;
    b = perm_at(cx + 1) + cy;
    ba = perm_at(b) + cz;
    bb = perm_at(b + 1) + cz;
    x1 = blend(u, corner_dot(perm_at(aa), fx, fy, fz), corner_dot(perm_at(ba), gx, fy, fz));
    x2 = blend(u, corner_dot(perm_at(ab), fx, gy, fz), corner_dot(perm_at(bb), gx, gy, fz));
    y1 = blend(v, x1, x2);
    x1 = blend(u, corner_dot(perm_at(aa + 1), fx, fy, gz),
               corner_dot(perm_at(ba + 1), gx, fy, gz));
    x2 = blend(u, corner_dot(perm_at(ab + 1), fx, gy, gz),
               corner_dot(perm_at(bb + 1), gx, gy, gz));
    y2 = blend(v, x1, x2);
    r = blend(w, y1, y2);
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r[17:0];
  endfunction

  // drive one request, hold it until accepted, then update the model
  task automatic push_request(input cmd_t cmd, input logic [7:0] idx, input logic [7:0] val,
                              input logic [23:0] px, input logic [23:0] py,
                              input logic [23:0] pz, input bit fixed_exp,
                              input logic signed [17:0] noise_exp);
    if (!quiet && send_gap == 0 && $urandom_range(0, 7) == 0)
      send_gap = $urandom_range(1, 8);
    while (send_gap > 0 && !quiet) begin
      in_ch.valid = 1'b0;
      send_gap--;
      @(negedge clk);
    end
    send_gap = 0;
    in_ch.valid = 1'b1;
    in_ch.cmd = cmd;
    in_ch.perm_index = idx;
    in_ch.perm_value = val;
    in_ch.coord_x = px;
    in_ch.coord_y = py;
    in_ch.coord_z = pz;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CMD_LOAD) begin
      perm_model[idx] = val;
    end else begin
      noise_expected_q.push_back(fixed_exp ? noise_exp : noise_predict(px, py, pz));
    end
    @(negedge clk);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return {8'($urandom), 16'h0000};
      1: return {8'($urandom), 16'hFFFF};
      2: return {8'hFF, 16'($urandom)};
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stall bursts, check on accept
  initial begin
    int stall_left;
    logic signed [17:0] want;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 8);
      if (stall_left > 0 && !quiet) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        stall_left = 0;
      end
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (noise_expected_q.size() == 0) begin
          $error("unexpected result noise_value=%0d", out_ch.noise_value);
          error_count++;
        end else begin
          want = noise_expected_q.pop_front();
          if (out_ch.noise_value !== want) begin
            $error("noise_value: expected %0d, got %0d", want, out_ch.noise_value);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    int order [256];
    int tmp, j, wait_cycles;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_LOAD;
    in_ch.perm_index = '0;
    in_ch.perm_value = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    foreach (perm_model[i]) perm_model[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill the whole table with a shuffled permutation before any evaluate
    for (int i = 0; i < 256; i++) order[i] = i;
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (int i = 0; i < 256; i++)
      push_request(CMD_LOAD, 8'(i), 8'(order[i]), '0, '0, '0, 0, '0);

    foreach (dir_rows[i])
      push_request(dir_rows[i].cmd, dir_rows[i].perm_index, dir_rows[i].perm_value,
                   dir_rows[i].coord_x, dir_rows[i].coord_y, dir_rows[i].coord_z,
                   dir_rows[i].fixed_exp, dir_rows[i].noise_exp);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1;
      if (n == RANDOM_ITEMS / 2) begin
        in_ch.valid = 1'b0;
        wait (noise_expected_q.size() == 0);
        @(negedge clk);
      end
      if ($urandom_range(0, 9) == 0)
        push_request(CMD_LOAD, 8'($urandom), 8'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom), 0, '0);
      else
        push_request(CMD_EVAL, 8'($urandom), 8'($urandom), rand_coord(), rand_coord(),
                     rand_coord(), 0, '0);
    end
    in_ch.valid = 1'b0;

    wait_cycles = 0;
    while (noise_expected_q.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (30) @(posedge clk);
    if (error_count == 0 && noise_expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (noise_expected_q.size() != 0)
        $error("noise_value: %0d results never arrived", noise_expected_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
